// ===== rtl/u2a_pkg.sv =====
// u2a_pkg: shared types, constants and the code point mapping function for
// the UTF-8 to ISO-8859-6 decoder. No dependencies.
package u2a_pkg;

	localparam int unsigned MaxLength  = 65535;
	localparam int unsigned CountW     = 16;
	localparam int unsigned CodeW      = 31;
	localparam int unsigned PendW      = 3;
	localparam int unsigned CountCapI  = (MaxLength < 65535) ? MaxLength : 65535;
	localparam logic [CountW-1:0] CountCap = CountW'(CountCapI);

	// code point limits
	localparam logic [CodeW-1:0] CpAsciiEnd = 31'd127;
	localparam logic [CodeW-1:0] CpAr1Lo    = 31'h0621;
	localparam logic [CodeW-1:0] CpAr1Hi    = 31'h063A;
	localparam logic [CodeW-1:0] CpAr2Lo    = 31'h0640;
	localparam logic [CodeW-1:0] CpAr2Hi    = 31'h0652;
	localparam logic [10:0]      CpArOffset = 11'd1376;

	// special points and their ISO-8859-6 bytes
	localparam logic [CodeW-1:0] CpNbsp     = 31'h00A0;
	localparam logic [CodeW-1:0] CpCurrency = 31'h00A4;
	localparam logic [CodeW-1:0] CpComma    = 31'h060C;
	localparam logic [CodeW-1:0] CpShy      = 31'h00AD;
	localparam logic [CodeW-1:0] CpSemi     = 31'h061B;
	localparam logic [CodeW-1:0] CpQuest    = 31'h061F;
	localparam logic [7:0] IsoNbsp     = 8'd160;
	localparam logic [7:0] IsoCurrency = 8'd164;
	localparam logic [7:0] IsoComma    = 8'd172;
	localparam logic [7:0] IsoShy      = 8'd173;
	localparam logic [7:0] IsoSemi     = 8'd187;
	localparam logic [7:0] IsoQuest    = 8'd191;

	// one decoded event handed from the front to the back
	typedef struct packed {
		logic [7:0] ch;
		logic       emit;
		logic       last;
	} u2a_event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} u2a_qstat_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] iso;
	} u2a_map_t;

	function automatic u2a_map_t map_code(input logic [CodeW-1:0] code);
		u2a_map_t   m;
		logic [10:0] diff;
		diff  = code[10:0] - CpArOffset;
		m.hit = 1'b1;
		m.iso = 8'd0;
		if (code < CpAsciiEnd) begin
			m.iso = code[7:0];
		end else if ((code >= CpAr1Lo && code <= CpAr1Hi) ||
		             (code >= CpAr2Lo && code <= CpAr2Hi)) begin
			m.iso = diff[7:0];
		end else begin
			case (code)
				CpNbsp:     m.iso = IsoNbsp;
				CpCurrency: m.iso = IsoCurrency;
				CpComma:    m.iso = IsoComma;
				CpShy:      m.iso = IsoShy;
				CpSemi:     m.iso = IsoSemi;
				CpQuest:    m.iso = IsoQuest;
				default:    m.hit = 1'b0;
			endcase
		end
		return m;
	endfunction

endpackage

// ===== rtl/u2a_front.sv =====
// u2a_front: accepts UTF-8 bytes, assembles sequences and maps code points.
// Depends on u2a_pkg.
module u2a_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                in_ready,
	input  u2a_pkg::u2a_qstat_t qstat,
	output logic                push,
	output u2a_pkg::u2a_event_t push_ev
);

	logic [u2a_pkg::PendW-1:0] pending_q, pending_d;
	logic [u2a_pkg::CodeW-1:0] acc_q, acc_d, acc_shift;
	logic                      ok_q, ok_d;
	logic                      take, emit;
	logic [7:0]                ch;
	u2a_pkg::u2a_map_t         m;

	assign in_ready  = !qstat.full;
	assign take      = in_valid && in_ready;
	assign acc_shift = {acc_q[u2a_pkg::CodeW-7:0], in_byte[5:0]};
	assign m         = u2a_pkg::map_code(acc_shift);

	always_comb begin
		pending_d = pending_q;
		acc_d     = acc_q;
		ok_d      = ok_q;
		emit      = 1'b0;
		ch        = 8'd0;
		if (pending_q != '0) begin
			pending_d = pending_q - 1'b1;
			acc_d     = acc_shift;
			if (in_byte[7:6] != 2'b10)
				ok_d = 1'b0;
			if (pending_q == 3'd1) begin
				if (ok_d && m.hit) begin
					emit = 1'b1;
					ch   = m.iso;
				end
				acc_d = '0;
				ok_d  = 1'b1;
			end
		end else if (!in_byte[7]) begin
			emit = 1'b1;
			ch   = in_byte;
		end else if (in_byte[7:6] == 2'b11 && in_byte[7:1] != 7'h7F) begin
			// lead byte: length from the leading ones
			ok_d = 1'b1;
			if (!in_byte[5]) begin
				pending_d = 3'd1;
				acc_d     = u2a_pkg::CodeW'(in_byte[4:0]);
			end else if (!in_byte[4]) begin
				pending_d = 3'd2;
				acc_d     = u2a_pkg::CodeW'(in_byte[3:0]);
			end else if (!in_byte[3]) begin
				pending_d = 3'd3;
				acc_d     = u2a_pkg::CodeW'(in_byte[2:0]);
			end else if (!in_byte[2]) begin
				pending_d = 3'd4;
				acc_d     = u2a_pkg::CodeW'(in_byte[1:0]);
			end else begin
				pending_d = 3'd5;
				acc_d     = u2a_pkg::CodeW'(in_byte[0]);
			end
		end
		// end of string: drop any open sequence
		if (in_last) begin
			pending_d = '0;
			acc_d     = '0;
			ok_d      = 1'b1;
		end
	end

	assign push         = take && (emit || in_last);
	assign push_ev.ch   = ch;
	assign push_ev.emit = emit;
	assign push_ev.last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			acc_q     <= '0;
			ok_q      <= 1'b1;
		end else if (take) begin
			pending_q <= pending_d;
			acc_q     <= acc_d;
			ok_q      <= ok_d;
		end
	end

endmodule

// ===== rtl/u2a_queue.sv =====
// u2a_queue: two-entry queue of decoded events between front and back.
// Depends on u2a_pkg.
module u2a_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u2a_pkg::u2a_event_t push_ev,
	input  logic                pop,
	output u2a_pkg::u2a_event_t pop_ev,
	output u2a_pkg::u2a_qstat_t qstat
);

	u2a_pkg::u2a_event_t slot_q [2];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign pop_ev      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/u2a_back.sv =====
// u2a_back: counts emitted characters and drives the registered result.
// Depends on u2a_pkg.
module u2a_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  u2a_pkg::u2a_qstat_t          qstat,
	input  u2a_pkg::u2a_event_t          pop_ev,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_char,
	output logic                         out_flag,
	output logic                         out_end,
	output logic [u2a_pkg::CountW-1:0]   out_count
);

	logic [u2a_pkg::CountW-1:0] count_q, count_d;
	logic                       valid_q;

	assign out_valid = valid_q;
	assign pop       = !qstat.empty && (!valid_q || out_ready);

	always_comb begin
		count_d = count_q;
		if (pop_ev.emit && count_q < u2a_pkg::CountCap)
			count_d = count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				count_q <= pop_ev.last ? '0 : count_d;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char  <= pop_ev.ch;
			out_flag  <= pop_ev.emit;
			out_end   <= pop_ev.last;
			out_count <= count_d;
		end
	end

endmodule

// ===== rtl/utf8_to_arabic_iso_decoder_top.sv =====
// utf8_to_arabic_iso_decoder_top: UTF-8 to ISO-8859-6 stream decoder.
// Depends on u2a_pkg, u2a_front, u2a_queue and u2a_back.
//
// Usage:
//   Input channel s_axis: one raw UTF-8 byte per item in s_axis_tdata, with
//   s_axis_tlast high on the final byte of a string.
//   Output channel m_axis: one item for every emitted character and one for
//   a final byte of a string that emits none. m_axis_tuser is high when
//   m_axis_tdata[7:0] holds a character (zero otherwise), m_axis_tlast
//   closes the string, and m_axis_tdata[23:8] is the running count of
//   emitted characters, final on the tlast item. Bytes that produce nothing
//   (lead and continuation bytes, dropped sequences) give no output item.
//   Throughput: one byte per cycle while m_axis_tready is high; the front
//   decodes a byte in the cycle it is accepted, so rate is set by the single
//   decode stage. Result path: the queue entry is written at the accepting
//   edge, the output register when the back pops that entry.
//   Back-pressure: when m_axis_tready is low the output register holds its
//   item, the two-entry queue fills, and s_axis_tready drops only once the
//   queue is full.
//   Reset: arst_n clears the sequence state, the count, the queue and the
//   output valid at once; items are accepted as soon as it is released.
module utf8_to_arabic_iso_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] out_char, [23:8] out_count
	output logic        m_axis_tuser,  // [0] char_valid
	output logic        m_axis_tlast
);

	u2a_pkg::u2a_qstat_t qstat;
	u2a_pkg::u2a_event_t push_ev, pop_ev;
	logic                push, pop;
	logic [7:0]          out_char;
	logic [15:0]         out_count;

	// front: decode bytes, map code points
	u2a_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.qstat    (qstat),
		.push     (push),
		.push_ev  (push_ev)
	);

	// queue: decouple decode from the output handshake
	u2a_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.pop_ev  (pop_ev),
		.qstat   (qstat)
	);

	// back: count characters, hold the result for the receiver
	u2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_ev    (pop_ev),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_flag  (m_axis_tuser),
		.out_end   (m_axis_tlast),
		.out_count (out_count)
	);

	assign m_axis_tdata = {out_count, out_char};

	// an item without a character exists only to close the string
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("result without character is not end of string");

	// a non-character result carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("out_char not zero without character");

	// a character result has counted at least itself
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] != 16'd0)
		else $error("count zero on emitted character");

	// never write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("push into full queue");

endmodule

// ===== test/utf8_to_arabic_iso_decoder_top_test.sv =====
// Self-checking testbench for utf8_to_arabic_iso_decoder_top: a directed table,
// then random UTF-8 strings, scored against typed-in rows or a local decoder model.
// Depends on u2a_pkg (count cap) and the decoder RTL.
module utf8_to_arabic_iso_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdleLimit   = 2000; // cycles with no item moving
	localparam int unsigned ArabicShift = 1376; // Arabic block to ISO-8859-6
	localparam int unsigned RandomItems = 370;
	localparam int unsigned DrainCycles = 8;    // wait after the last result

	// One result as the block reports it.
	typedef struct packed {
		logic [7:0]  ch;
		logic        valid;
		logic        eos;
		logic [15:0] count;
	} iso_result_t;

	// One planned input byte.
	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} utf8_item_t;

	// Directed row: byte, last flag, and a typed-in result where it is obvious.
	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		logic        typed;
		iso_result_t r;
	} dir_row_t;

	localparam int DirRows = 24;
	localparam dir_row_t DirTable [DirRows] = '{
		// lowest and highest ASCII, each a whole string
		'{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 16'd1}},
		'{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 16'd1}},
		// invalid lead and stray continuation: nothing emitted
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
		'{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
		// FE skipped, then no-break space, question mark, sukun
		'{8'hFE, 1'b0, 1'b0, '0},
		'{8'hC2, 1'b0, 1'b0, '0},
		'{8'hA0, 1'b0, 1'b0, '0},
		'{8'hD8, 1'b0, 1'b0, '0},
		'{8'h9F, 1'b0, 1'b0, '0},
		'{8'hD9, 1'b0, 1'b0, '0},
		'{8'h92, 1'b0, 1'b0, '0},
		// overlong 127 from two bytes: unmapped
		'{8'hC1, 1'b0, 1'b0, '0},
		'{8'hBF, 1'b0, 1'b0, '0},
		// bad continuation: ASCII swallowed, sequence dropped
		'{8'hE0, 1'b0, 1'b0, '0},
		'{8'h41, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// lead left pending at the end of the string
		'{8'hF4, 1'b1, 1'b0, '0},
		// six-byte overlong zero
		'{8'hFC, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, '0},
		// capital A, single byte string through the predictor
		'{8'h41, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] in_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // [7:0] out_char, [23:8] out_count
	logic        m_axis_tuser;  // [0] char_valid
	logic        m_axis_tlast;

	// Decoder model state.
	logic [2:0]  dec_pending;
	logic [30:0] dec_code;
	logic        dec_ok;
	logic [15:0] dec_count;

	iso_result_t iso_expected [$];
	utf8_item_t  byte_plan [$];

	int unsigned fault_count;
	int unsigned bytes_sent;
	int unsigned results_seen;
	int unsigned chars_seen;
	int unsigned strings_seen;
	int unsigned idle_cycles;
	logic        calm;  // both sides stop idling while high

	utf8_to_arabic_iso_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ISO-8859-6 byte for a code point; bit 8 set when it has none.
	function automatic logic [8:0] iso_of(input logic [30:0] cp);
		logic [30:0] shifted;
		shifted = cp - 31'(ArabicShift);
		if (cp < 31'd127)
			return {1'b0, cp[7:0]};
		if ((cp >= 31'h621 && cp <= 31'h63A) || (cp >= 31'h640 && cp <= 31'h652))
			return {1'b0, shifted[7:0]};
		case (cp)
			31'h0A0: return 9'd160;
			31'h0A4: return 9'd164;
			31'h60C: return 9'd172;
			31'h0AD: return 9'd173;
			31'h61B: return 9'd187;
			31'h61F: return 9'd191;
			default: return 9'h100;
		endcase
	endfunction

	task automatic clear_decoder();
		dec_pending = '0;
		dec_code    = '0;
		dec_ok      = 1'b1;
		dec_count   = '0;
	endtask

	// Advance the model by one accepted byte; got says whether a result follows.
	task automatic decode_byte(input logic [7:0] b, input logic l,
	                           output logic got, output iso_result_t r);
		logic       emit;
		logic [7:0] ch;
		logic [8:0] m;
		emit = 1'b0;
		ch   = '0;
		if (dec_pending != 0) begin
			// anything counts as a continuation while one is owed
			if (b[7:6] != 2'b10)
				dec_ok = 1'b0;
			dec_code    = {dec_code[24:0], b[5:0]};
			dec_pending = dec_pending - 3'd1;
			if (dec_pending == 0) begin
				if (dec_ok) begin
					m = iso_of(dec_code);
					if (!m[8]) begin
						emit = 1'b1;
						ch   = m[7:0];
					end
				end
				dec_code = '0;
				dec_ok   = 1'b1;
			end
		end else if (b < 8'h80) begin
			emit = 1'b1;
			ch   = b;
		end else if (b >= 8'hC0 && b < 8'hFE) begin
			if (b < 8'hE0) begin
				dec_pending = 3'd1;
				dec_code    = 31'(b & 8'h1F);
			end else if (b < 8'hF0) begin
				dec_pending = 3'd2;
				dec_code    = 31'(b & 8'h0F);
			end else if (b < 8'hF8) begin
				dec_pending = 3'd3;
				dec_code    = 31'(b & 8'h07);
			end else if (b < 8'hFC) begin
				dec_pending = 3'd4;
				dec_code    = 31'(b & 8'h03);
			end else begin
				dec_pending = 3'd5;
				dec_code    = 31'(b & 8'h01);
			end
			dec_ok = 1'b1;
		end
		if (emit && dec_count < u2a_pkg::CountCap)
			dec_count = dec_count + 16'd1;
		got = emit || l;
		r   = '{ch, emit, l, dec_count};
		if (l)
			clear_decoder();
	endtask

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 9));
	endfunction

	// Offer one byte, hold it until taken, then queue its expected result from the model or the typed row.
	task automatic send_item(input logic [7:0] b, input logic l,
	                         input logic typed, input iso_result_t typed_r);
		int          gap;
		logic        got;
		iso_result_t r;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b, l, got, r);
		if (typed)
			iso_expected.push_back(typed_r);
		else if (got)
			iso_expected.push_back(r);
		bytes_sent++;
	endtask

	// Hold off the sender until every expected result has come out.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (iso_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic plan_push(input logic [7:0] b);
		byte_plan.push_back('{b, 1'b0});
	endtask

	// Encode cp as an n-byte sequence, keep conts continuations, and spoil
	// continuation number bad_at (0 spoils none).
	task automatic plan_code(input int unsigned cp, input int n, input int conts,
	                         input int bad_at);
		logic [7:0] prefix;
		logic [7:0] mask;
		logic [7:0] b;
		int         k;
		prefix = ~(8'hFF >> n);
		mask   = 8'hFF >> (n + 1);
		plan_push(prefix | (8'(cp >> (6 * (n - 1))) & mask));
		for (k = 1; k <= conts; k++) begin
			b = 8'h80 | (8'(cp >> (6 * (n - 1 - k))) & 8'h3F);
			if (k == bad_at) begin
				b = 8'($urandom);
				if (b[7:6] == 2'b10)
					b = b ^ 8'h40;
			end
			plan_push(b);
		end
	endtask

	// Plan one random string: mostly well-formed text, with noise mixed in.
	task automatic plan_string();
		int          nchars;
		int          kind;
		int          n;
		int          k;
		int unsigned cp;
		utf8_item_t  tail;
		nchars = $urandom_range(1, 10);
		for (k = 0; k < nchars; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				plan_push(8'($urandom_range(0, 127)));
			end else if (kind < 55) begin
				// Arabic block, gap points included
				plan_code($urandom_range(32'h621, 32'h652), 2, 1, 0);
			end else if (kind < 63) begin
				case ($urandom_range(0, 7))
					0: cp = 32'h0A0;
					1: cp = 32'h0A4;
					2: cp = 32'h0AD;
					3: cp = 32'h60C;
					4: cp = 32'h61B;
					5: cp = 32'h61F;
					6: cp = 32'h07F;
					default: cp = $urandom_range(32'h80, 32'h7FF);
				endcase
				n = $urandom_range(2, 3);
				plan_code(cp, n, n - 1, 0);
			end else if (kind < 75) begin
				// any length, often overlong
				n  = $urandom_range(2, 6);
				cp = $urandom_range(0, 1) ? $urandom_range(0, 32'h7FF)
				                          : ($urandom & ((32'h1 << (5 * n + 1)) - 1));
				plan_code(cp, n, n - 1, 0);
			end else if (kind < 83) begin
				case ($urandom_range(0, 3))
					0: plan_push(8'($urandom_range(8'h80, 8'hBF)));
					1: plan_push(8'hFE);
					2: plan_push(8'hFF);
					default: plan_push(8'($urandom));
				endcase
			end else if (kind < 93) begin
				n = $urandom_range(2, 6);
				plan_code($urandom_range(32'h621, 32'h652), n, n - 1, $urandom_range(1, n - 1));
			end else begin
				// bare lead: swallows whatever follows
				plan_code($urandom, $urandom_range(2, 6), 0, 0);
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			// cut the string inside a sequence
			n = $urandom_range(2, 6);
			plan_code($urandom_range(32'h621, 32'h652), n, $urandom_range(0, n - 2), 0);
		end
		tail   = byte_plan.pop_back();
		tail.l = 1'b1;
		byte_plan.push_back(tail);
	endtask

	// Receiver: idle at random, take each result and score it in order.
	initial begin
		int          gap;
		iso_result_t want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			repeat (gap) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			results_seen++;
			if (m_axis_tuser)
				chars_seen++;
			if (m_axis_tlast)
				strings_seen++;
			if (iso_expected.size() == 0) begin
				$error("result with none expected: out_char %h char_valid %b end %b count %0d",
				       m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[23:8]);
				fault_count++;
			end else begin
				want = iso_expected.pop_front();
				if (m_axis_tdata[7:0] !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, m_axis_tdata[7:0]);
					fault_count++;
				end
				if (m_axis_tuser !== want.valid) begin
					$error("char_valid: expected %b, actual %b", want.valid, m_axis_tuser);
					fault_count++;
				end
				if (m_axis_tlast !== want.eos) begin
					$error("end_of_string: expected %b, actual %b", want.eos, m_axis_tlast);
					fault_count++;
				end
				if (m_axis_tdata[23:8] !== want.count) begin
					$error("out_count: expected %0d, actual %0d", want.count, m_axis_tdata[23:8]);
					fault_count++;
				end
			end
		end
	end

	// Watchdog: stop the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Timeout: %0d cycles with no item moving", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random strings, drain, verdict.
	initial begin
		int          i;
		utf8_item_t  it;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		calm          = 1'b0;
		fault_count   = 0;
		bytes_sent    = 0;
		results_seen  = 0;
		chars_seen    = 0;
		strings_seen  = 0;
		idle_cycles   = 0;
		clear_decoder();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: walk the table; typed rows bypass the model's result.
		for (i = 0; i < DirRows; i++)
			send_item(DirTable[i].b, DirTable[i].l, DirTable[i].typed, DirTable[i].r);

		// Pause the sender until the block has delivered everything.
		drain_results();

		// Random: plan whole strings, then stream them.
		while (byte_plan.size() < RandomItems)
			plan_string();
		i = 0;
		while (byte_plan.size() != 0) begin
			// stretches with no idling on either side
			calm = ((i % 100) >= 40) && ((i % 100) < 60);
			if (i == RandomItems / 2)
				drain_results();
			it = byte_plan.pop_front();
			send_item(it.b, it.l, 1'b0, '0);
			i++;
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (iso_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes; checked %0d results (%0d characters, %0d strings).",
		         bytes_sent, results_seen, chars_seen, strings_seen);
		$display("Covered ASCII, Arabic and special points, overlong, broken and cut sequences.");
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/u2a_pkg.sv
rtl/u2a_front.sv
rtl/u2a_queue.sv
rtl/u2a_back.sv
rtl/utf8_to_arabic_iso_decoder_top.sv
test/utf8_to_arabic_iso_decoder_top_test.sv
